// File: hdl/ncl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest crystal lookup package
// Shared widths, codes and the scan token type of the crystal lookup core.
// ----------------------------------------------------------------------------
package ncl_pkg;

   localparam int COORD_W   = 16;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int DIST_W    = SQ_W + 1;
   localparam int SLOT_W    = 6;
   localparam int CRYSTAL_W = 6;

   localparam logic signed [COORD_W-1:0] ONE_Q14     = 16'sd16384;
   localparam logic signed [COORD_W-1:0] MINUS_ONE_Q14 = -16'sd16384;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   localparam logic STATUS_FOUND = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [DIST_W-1:0] sq_dist;
   } token_type;

endpackage

// File: hdl/ncl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest crystal lookup cell
// Holds one crystal peak position, keeps its squared distance to the current
// event and passes the running best distance and index on to the next cell.
// ----------------------------------------------------------------------------
module ncl_cell #(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic signed [ncl_pkg::COORD_W-1:0] wr_x,
   input  logic signed [ncl_pkg::COORD_W-1:0] wr_y,
   input  logic signed [ncl_pkg::COORD_W-1:0] query_x,
   input  logic signed [ncl_pkg::COORD_W-1:0] query_y,
   input  ncl_pkg::token_type                 tok_in,
   input  logic [IDX_W-1:0]                   idx_in,
   output ncl_pkg::token_type                 tok_out,
   output logic [IDX_W-1:0]                   idx_out
);
   import ncl_pkg::*;

   logic signed [COORD_W-1:0] peak_x_ff;
   logic signed [COORD_W-1:0] peak_y_ff;
   logic signed [DIFF_W-1:0]  diff_x;
   logic signed [DIFF_W-1:0]  diff_y;
   logic signed [SQ_W-1:0]    prod_x;
   logic signed [SQ_W-1:0]    prod_y;
   logic [SQ_W-1:0]           sq_x_ff;
   logic [SQ_W-1:0]           sq_y_ff;
   logic [DIST_W-1:0]         own_dist;
   logic                      take;
   logic                      tok_valid_ff;
   logic [DIST_W-1:0]         tok_dist_ff;
   logic [IDX_W-1:0]          idx_ff;

   assign diff_x   = DIFF_W'(peak_x_ff) - DIFF_W'(query_x);
   assign diff_y   = DIFF_W'(peak_y_ff) - DIFF_W'(query_y);
   assign prod_x   = diff_x * diff_x;
   assign prod_y   = diff_y * diff_y;
   assign own_dist = DIST_W'(sq_x_ff) + DIST_W'(sq_y_ff);
   assign take     = own_dist < tok_in.sq_dist;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         peak_x_ff <= wr_x;
         peak_y_ff <= wr_y;
      end
      sq_x_ff     <= unsigned'(prod_x);
      sq_y_ff     <= unsigned'(prod_y);
      tok_dist_ff <= take ? own_dist : tok_in.sq_dist;
      idx_ff      <= take ? IDX_W'(CELL_INDEX) : idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_in.valid;
      end
   end

   assign tok_out.valid   = tok_valid_ff;
   assign tok_out.sq_dist = tok_dist_ff;
   assign idx_out         = idx_ff;

endmodule

// File: hdl/nearest_crystal_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest crystal lookup core
// Finds the crystal peak nearest to a detector event position by squared
// Euclidean distance over a chain of cells, one cell per crystal.
//
//   Channel   Ports                                       Direction
//   request   req_valid req_stall req_cmd req_slot
//             req_coord_x req_coord_y                     in
//   response  rsp_valid rsp_stall rsp_crystal rsp_status  out
//
// A load word gives no response.
// A classify word in range first registers the squared distances in every
// cell, then the best-so-far token walks the cell chain one cell per cycle.
// An out-of-range word skips the scan and goes straight to its response.
// Reset clears control state only; the peak table is undefined until loaded.
// Requests are stalled from an accepted classify word until its response
// enters the output register, which holds while rsp_stall is high.
// ----------------------------------------------------------------------------
module nearest_crystal_lookup_core #(
   parameter int NUM_CRYSTALS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic [ncl_pkg::SLOT_W-1:0]          req_slot,
   input  logic signed [ncl_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [ncl_pkg::COORD_W-1:0]  req_coord_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ncl_pkg::CRYSTAL_W-1:0]       rsp_crystal,
   output logic                                rsp_status
);
   import ncl_pkg::*;

   localparam int IDX_W = (NUM_CRYSTALS > 1) ? $clog2(NUM_CRYSTALS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;
   logic                      launch_ff;
   logic signed [COORD_W-1:0] query_x_ff;
   logic signed [COORD_W-1:0] query_y_ff;
   logic [CRYSTAL_W-1:0]      result_crystal_ff;
   logic                      result_status_ff;
   logic                      rsp_valid_ff;
   logic [CRYSTAL_W-1:0]      rsp_crystal_ff;
   logic                      rsp_status_ff;
   logic                      req_accept;
   logic                      out_of_range;
   logic                      out_free;
   logic                      scan_end;

   token_type        tok_chain [0:NUM_CRYSTALS];
   logic [IDX_W-1:0] idx_chain [0:NUM_CRYSTALS];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_of_range = (req_coord_x > ONE_Q14) || (req_coord_x < MINUS_ONE_Q14) ||
                         (req_coord_y > ONE_Q14) || (req_coord_y < MINUS_ONE_Q14);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_end   = tok_chain[NUM_CRYSTALS].valid;

   assign tok_chain[0].valid   = launch_ff;
   assign tok_chain[0].sq_dist = '1;
   assign idx_chain[0]         = '0;

   for (genvar i = 0; i < NUM_CRYSTALS; i++) begin : g_cell
      logic wr_en;

      assign wr_en = req_accept && (req_cmd == CMD_LOAD) &&
                     ({{(32 - SLOT_W){1'b0}}, req_slot} == 32'(i));

      ncl_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr_en),
         .wr_x    (req_coord_x),
         .wr_y    (req_coord_y),
         .query_x (query_x_ff),
         .query_y (query_y_ff),
         .tok_in  (tok_chain[i]),
         .idx_in  (idx_chain[i]),
         .tok_out (tok_chain[i+1]),
         .idx_out (idx_chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_cmd == CMD_CLASSIFY)) begin
               state_in = out_of_range ? ST_DONE : ST_SQUARE;
            end
         end
         ST_SQUARE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= (state_ff == ST_SQUARE);
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_cmd == CMD_CLASSIFY)) begin
         query_x_ff        <= req_coord_x;
         query_y_ff        <= req_coord_y;
         result_crystal_ff <= '0;
         result_status_ff  <= STATUS_RANGE;
      end else if ((state_ff == ST_SCAN) && scan_end) begin
         result_crystal_ff <= CRYSTAL_W'(idx_chain[NUM_CRYSTALS]);
         result_status_ff  <= STATUS_FOUND;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_crystal_ff <= result_crystal_ff;
         rsp_status_ff  <= result_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_crystal = rsp_crystal_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: hdl/ncl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest crystal lookup checker
// Port-level checks on the crystal lookup core, attached by a bind statement.
// ----------------------------------------------------------------------------
module ncl_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ncl_pkg::CRYSTAL_W-1:0]       rsp_crystal,
   input logic                                rsp_status
);
   import ncl_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Reset did not clear the request stall and response valid.");

   a_load_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_LOAD) |=> !req_stall)
      else $error("A load word stalled the request channel.");

   a_classify_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_CLASSIFY) |=> req_stall)
      else $error("A classify word did not stall the request channel.");

   a_range_crystal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_RANGE) |-> (rsp_crystal == '0))
      else $error("An out-of-range response carries a nonzero crystal.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crystal) && $stable(rsp_status))
      else $error("A stalled response word changed.");

endmodule

bind nearest_crystal_lookup_core ncl_checker u_ncl_checker (.*);
